[hdl/sfft_pkg.sv]
// ----------------------------------------------------------------------------
// sfft_pkg: shared types and constants for the force-feedback torque block
// Q16.16 format constants, transaction payload types, the tanh table and
// 32-bit saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sfft_pkg;

  localparam int DATA_W        = 32;
  localparam int GAIN_W        = 31;
  localparam int FRAC_BITS     = 16;
  localparam int TANH_DEPTH    = 256;
  localparam int END_STOP_GAIN = 100;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam int TANH_W     = FRAC_BITS + 1;
  localparam int TANH_IDX_W = $clog2(TANH_DEPTH + 1);
  localparam int TANH_AW    = $clog2(TANH_DEPTH);
  localparam int BAND_W     = TANH_W + 2;
  // four 32-bit terms plus the end-stop term, which grows by the gain
  localparam int ACC_W      = DATA_W + $clog2(END_STOP_GAIN + 1) + 3;
  localparam int CFG_IDX_W  = 3;

  // 8/TANH_DEPTH in Q30, the exponent step of the table
  localparam logic [63:0] TANH_Y = (64'd8 << 30) / TANH_DEPTH;

  localparam logic [DATA_W-1:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [DATA_W-1:0] LFSR_TAPS = 32'hD000_0001;
  localparam logic [GAIN_W-1:0] END_STOP_RESET = GAIN_W'(98304);

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ORIGIN        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN         = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_GAIN       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN        = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RUMBLE_GAIN         = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_IMPACT        = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_RUMBLE_SPEED_IMPACT = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_END_STOP_ANGLE      = CFG_IDX_W'(7);

  typedef struct packed {
    logic signed [DATA_W-1:0] wheel_angle;
    logic signed [DATA_W-1:0] wheel_speed;
    logic signed [DATA_W-1:0] car_speed;
    logic        [GAIN_W-1:0] road_roughness;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] torque;
    logic                     saturated;
  } out_item_t;

  typedef logic [TANH_W-1:0] tanh_tab_t [0:TANH_DEPTH];

  // restoring division, used only while the tanh table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], n[j]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // entry i = tanh(4*i/TANH_DEPTH); exp(-8/TANH_DEPTH) from a 12-term series in Q30
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] b;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] num;
    int          k;
    int          i;
    y    = TANH_Y;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (k = 1; k <= 12; k++) begin
      term = udiv64((term * y) >> 30, 64'(k));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
    end
    b = sum;
    p = 64'd1 << 30;
    for (i = 0; i <= TANH_DEPTH; i++) begin
      den    = (64'd1 << 30) + p;
      num    = ((64'd1 << 30) - p) << FRAC_BITS;
      tab[i] = TANH_W'(udiv64(num + (den >> 1), den));
      p      = (p * b + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();
  localparam logic [TANH_W-1:0] TANH_LAST = TANH_TAB[TANH_DEPTH];

  function automatic logic fits32(input logic signed [ACC_W-1:0] v);
    return (&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (fits32(v)) return v[DATA_W-1:0];
    else if (v[ACC_W-1]) return S32_MIN;
    else return S32_MAX;
  endfunction

endpackage

`default_nettype wire

[hdl/sfft_mul.sv]
// ----------------------------------------------------------------------------
// sfft_mul: digit-serial fixed-point multiplier
// Sign-magnitude Q16.16 product, four multiplier bits per cycle, truncated
// toward zero and saturated to 32 bits. Result is valid on the done pulse
// and holds until the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module sfft_mul import sfft_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] res_o
);

  localparam int DIGIT_W = 4;
  localparam int DIGITS  = DATA_W / DIGIT_W;
  localparam int CNT_W   = $clog2(DIGITS);
  localparam int SUM_W   = DATA_W + DIGIT_W;
  localparam int M_W     = 2 * DATA_W - FRAC_BITS;

  logic                     run_q;
  logic                     fin_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  logic [DATA_W-1:0]        mag_a_q;
  logic [DATA_W-1:0]        hi_q;
  logic [DATA_W-1:0]        lo_q;
  logic signed [DATA_W-1:0] res_q;

  logic [DATA_W-1:0]        mag_a;
  logic [DATA_W-1:0]        mag_b;
  logic [SUM_W-1:0]         pp;
  logic [SUM_W-1:0]         sum;
  logic [2*DATA_W-1:0]      prod;
  logic [M_W-1:0]           m;
  logic                     big;
  logic signed [DATA_W-1:0] res_d;

  assign mag_a = a_i[DATA_W-1] ? DATA_W'(-a_i) : a_i;
  assign mag_b = b_i[DATA_W-1] ? DATA_W'(-b_i) : b_i;

  // one digit of the multiplier per cycle; low product bits shift into lo_q
  assign pp  = SUM_W'(mag_a_q) * SUM_W'(lo_q[DIGIT_W-1:0]);
  assign sum = SUM_W'(hi_q) + pp;

  assign prod = {hi_q, lo_q};
  assign m    = prod[2*DATA_W-1:FRAC_BITS];
  assign big  = |m[M_W-1:DATA_W-1];

  always_comb begin
    if (neg_q) res_d = big ? S32_MIN : DATA_W'(-$signed(m[DATA_W-1:0]));
    else       res_d = big ? S32_MAX : $signed(m[DATA_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIGITS - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q   <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      mag_a_q <= mag_a;
      hi_q    <= '0;
      lo_q    <= mag_b;
    end else if (run_q) begin
      hi_q <= sum[SUM_W-1:DIGIT_W];
      lo_q <= {sum[DIGIT_W-1:0], lo_q[DATA_W-1:DIGIT_W]};
    end
    if (fin_q) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[hdl/steering_force_feedback_torque.sv]
// ----------------------------------------------------------------------------
// steering_force_feedback_torque: steering wheel force-feedback torque
// One transaction per control tick: wheel angle, wheel speed, car speed and
// road roughness in, saturated Q16.16 torque out. Torque is the sum of a
// centring spring scaled by tanh of car speed, friction toward a drift angle
// that follows the wheel within a speed-dependent band, damping, LFSR road
// rumble and an end-stop penalty. All nine products run one after another on
// a single multiplier that takes four bits per cycle. The input side is
// stalled while an item is in work, so a new item waits until the last is
// through all nine products and any wait on out_stall_i; a finished result
// waits in the output register while the next item is accepted. The
// configuration registers are written through a simple write port; the user
// must do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_force_feedback_torque import sfft_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = ST_W'(0);
  localparam logic [ST_W-1:0] ST_ANGLE  = ST_W'(1);
  localparam logic [ST_W-1:0] ST_MSTART = ST_W'(2);
  localparam logic [ST_W-1:0] ST_MWAIT  = ST_W'(3);
  localparam logic [ST_W-1:0] ST_TANH   = ST_W'(4);
  localparam logic [ST_W-1:0] ST_DRIFT  = ST_W'(5);
  localparam logic [ST_W-1:0] ST_DIFF   = ST_W'(6);
  localparam logic [ST_W-1:0] ST_EXC    = ST_W'(7);
  localparam logic [ST_W-1:0] ST_EPR    = ST_W'(8);
  localparam logic [ST_W-1:0] ST_EADD   = ST_W'(9);
  localparam logic [ST_W-1:0] ST_FIN    = ST_W'(10);

  // products, in the order they are formed
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_SPRING_TANH  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_RUMBLE_TANH  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_SPRING_ANGLE = OP_W'(2);
  localparam logic [OP_W-1:0] OP_SPRING_SCALE = OP_W'(3);
  localparam logic [OP_W-1:0] OP_FRICTION     = OP_W'(4);
  localparam logic [OP_W-1:0] OP_DAMPING      = OP_W'(5);
  localparam logic [OP_W-1:0] OP_NOISE_ROUGH  = OP_W'(6);
  localparam logic [OP_W-1:0] OP_NOISE_GAIN   = OP_W'(7);
  localparam logic [OP_W-1:0] OP_NOISE_SCALE  = OP_W'(8);

  localparam int TSUM_W = FRAC_BITS + 2 + TANH_IDX_W;
  localparam logic signed [ACC_W-1:0] ES_GAIN = ACC_W'(END_STOP_GAIN);

  // configuration
  logic signed [DATA_W-1:0] angle_origin_q;
  logic [GAIN_W-1:0]        spring_gain_q;
  logic [GAIN_W-1:0]        friction_gain_q;
  logic [GAIN_W-1:0]        damping_gain_q;
  logic [GAIN_W-1:0]        rumble_gain_q;
  logic [GAIN_W-1:0]        speed_impact_q;
  logic [GAIN_W-1:0]        rumble_speed_impact_q;
  logic [GAIN_W-1:0]        end_stop_angle_q;

  // control and state
  logic [ST_W-1:0]          state_q, state_d;
  logic [OP_W-1:0]          op_q, op_d;
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        lfsr_q;
  logic signed [DATA_W-1:0] drift_q, drift_d;

  // datapath
  in_item_t                 item_q;
  logic signed [DATA_W-1:0] angle_q;
  logic signed [DATA_W-1:0] diff_q;
  logic signed [TANH_W:0]   tv_q;
  logic signed [TANH_W:0]   tr_q;
  logic signed [BAND_W-1:0] band_q;
  logic signed [DATA_W:0]   excess_q;
  logic signed [ACC_W-1:0]  es_q;
  logic signed [ACC_W-1:0]  torque_q, torque_d;
  out_item_t                out_q;

  logic                     accept;
  logic                     out_free;
  logic                     mul_start;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic                     mul_done;
  logic signed [DATA_W-1:0] mul_res;
  logic signed [ACC_W-1:0]  res_acc;

  logic signed [DATA_W-1:0]    angle_w;
  logic [DATA_W-1:0]           lfsr_step;
  logic signed [FRAC_BITS-1:0] noise;
  logic [DATA_W-1:0]           mul_abs;
  logic [TSUM_W-1:0]           tanh_num;
  logic [TANH_IDX_W-1:0]       tanh_idx;
  logic [TANH_W-1:0]           tanh_ent;
  logic signed [TANH_W:0]      tanh_val;
  logic signed [BAND_W-1:0]    band_w;
  logic signed [DATA_W+1:0]    drift_diff;
  logic signed [DATA_W+1:0]    band_x;
  logic signed [DATA_W-1:0]    drift_hi;
  logic signed [DATA_W-1:0]    drift_lo;
  logic signed [DATA_W-1:0]    diff_sat;
  logic signed [DATA_W:0]      angle_x;
  logic signed [DATA_W:0]      esa_x;
  logic signed [DATA_W:0]      excess_w;
  logic signed [ACC_W-1:0]     es_w;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------
  // Arithmetic pieces
  // ---------------------------------------------------------------------
  assign angle_w = sat32(ACC_W'(item_q.wheel_angle) - ACC_W'(angle_origin_q));

  assign lfsr_step = {1'b0, lfsr_q[DATA_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
  // low fraction bits minus one half is the same as flipping their top bit
  assign noise = {~lfsr_q[FRAC_BITS-1], lfsr_q[FRAC_BITS-2:0]};

  // tanh lookup on the product just finished
  assign mul_abs  = mul_res[DATA_W-1] ? DATA_W'(-mul_res) : mul_res;
  assign tanh_num = TSUM_W'(mul_abs[FRAC_BITS+1:0]) * TSUM_W'(TANH_DEPTH)
                  + TSUM_W'(2 * ONE);
  assign tanh_idx = (mul_abs >= DATA_W'(4 * ONE)) ? TANH_IDX_W'(TANH_DEPTH)
                  : tanh_num[FRAC_BITS+2 +: TANH_IDX_W];
  assign tanh_ent = (tanh_idx == TANH_IDX_W'(TANH_DEPTH)) ? TANH_LAST
                  : TANH_TAB[tanh_idx[TANH_AW-1:0]];
  assign tanh_val = mul_res[DATA_W-1] ? -$signed({1'b0, tanh_ent}) : $signed({1'b0, tanh_ent});
  assign band_w   = BAND_W'(ONE) - BAND_W'(tanh_val);

  // drift angle is dragged to stay within band of the wheel angle
  assign drift_diff = (DATA_W+2)'(drift_q) - (DATA_W+2)'(angle_q);
  assign band_x     = (DATA_W+2)'(band_q);
  assign drift_hi   = sat32(ACC_W'(angle_q) + ACC_W'(band_q));
  assign drift_lo   = sat32(ACC_W'(angle_q) - ACC_W'(band_q));

  always_comb begin
    if (drift_diff > band_x)       drift_d = drift_hi;
    else if (drift_diff < -band_x) drift_d = drift_lo;
    else                           drift_d = drift_q;
  end

  assign diff_sat = sat32(ACC_W'(drift_q) - ACC_W'(angle_q));

  // end stop: distance beyond +-end_stop_angle, zero inside
  assign angle_x = (DATA_W+1)'(angle_q);
  assign esa_x   = $signed({2'b00, end_stop_angle_q});

  always_comb begin
    if (angle_x > esa_x)       excess_w = angle_x - esa_x;
    else if (angle_x < -esa_x) excess_w = angle_x + esa_x;
    else                       excess_w = '0;
  end

  assign es_w = ACC_W'(excess_q) * ES_GAIN;

  assign res_acc = ACC_W'(mul_res);

  always_comb begin
    case (op_q)
      OP_SPRING_SCALE, OP_DAMPING: torque_d = torque_q - res_acc;
      OP_FRICTION, OP_NOISE_SCALE: torque_d = torque_q + res_acc;
      default:                     torque_d = torque_q;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------
  always_comb begin
    case (op_q)
      OP_SPRING_TANH: begin
        mul_a = $signed({1'b0, speed_impact_q});
        mul_b = item_q.car_speed;
      end
      OP_RUMBLE_TANH: begin
        mul_a = $signed({1'b0, rumble_speed_impact_q});
        mul_b = item_q.car_speed;
      end
      OP_SPRING_ANGLE: begin
        mul_a = angle_q;
        mul_b = $signed({1'b0, spring_gain_q});
      end
      OP_SPRING_SCALE: begin
        mul_a = mul_res;
        mul_b = DATA_W'(tv_q);
      end
      OP_FRICTION: begin
        mul_a = diff_q;
        mul_b = $signed({1'b0, friction_gain_q});
      end
      OP_DAMPING: begin
        mul_a = item_q.wheel_speed;
        mul_b = $signed({1'b0, damping_gain_q});
      end
      OP_NOISE_ROUGH: begin
        mul_a = DATA_W'(noise);
        mul_b = $signed({1'b0, item_q.road_roughness});
      end
      OP_NOISE_GAIN: begin
        mul_a = mul_res;
        mul_b = $signed({1'b0, rumble_gain_q});
      end
      OP_NOISE_SCALE: begin
        mul_a = mul_res;
        mul_b = DATA_W'(tr_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sfft_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    mul_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        op_d    = OP_SPRING_TANH;
        state_d = ST_MSTART;
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_d   = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          case (op_q)
            OP_SPRING_TANH, OP_RUMBLE_TANH: state_d = ST_TANH;
            OP_SPRING_SCALE:                state_d = ST_DRIFT;
            OP_NOISE_SCALE:                 state_d = ST_EXC;
            default: begin
              op_d    = op_q + OP_W'(1);
              state_d = ST_MSTART;
            end
          endcase
        end
      end
      ST_TANH: begin
        op_d    = op_q + OP_W'(1);
        state_d = ST_MSTART;
      end
      ST_DRIFT: state_d = ST_DIFF;
      ST_DIFF: begin
        op_d    = op_q + OP_W'(1);
        state_d = ST_MSTART;
      end
      ST_EXC:  state_d = ST_EPR;
      ST_EPR:  state_d = ST_EADD;
      ST_EADD: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (state_q == ST_FIN && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= ST_IDLE;
      op_q                  <= OP_SPRING_TANH;
      out_valid_q           <= 1'b0;
      lfsr_q                <= LFSR_SEED;
      drift_q               <= '0;
      angle_origin_q        <= '0;
      spring_gain_q         <= '0;
      friction_gain_q       <= '0;
      damping_gain_q        <= '0;
      rumble_gain_q         <= '0;
      speed_impact_q        <= '0;
      rumble_speed_impact_q <= '0;
      end_stop_angle_q      <= END_STOP_RESET;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_ANGLE) lfsr_q <= lfsr_step;
      if (state_q == ST_DRIFT) drift_q <= drift_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ANGLE_ORIGIN:        angle_origin_q        <= cfg_data_i;
          REG_SPRING_GAIN:         spring_gain_q         <= cfg_data_i[GAIN_W-1:0];
          REG_FRICTION_GAIN:       friction_gain_q       <= cfg_data_i[GAIN_W-1:0];
          REG_DAMPING_GAIN:        damping_gain_q        <= cfg_data_i[GAIN_W-1:0];
          REG_RUMBLE_GAIN:         rumble_gain_q         <= cfg_data_i[GAIN_W-1:0];
          REG_SPEED_IMPACT:        speed_impact_q        <= cfg_data_i[GAIN_W-1:0];
          REG_RUMBLE_SPEED_IMPACT: rumble_speed_impact_q <= cfg_data_i[GAIN_W-1:0];
          REG_END_STOP_ANGLE:      end_stop_angle_q      <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) item_q <= in_i;
      end
      ST_ANGLE: begin
        angle_q  <= angle_w;
        torque_q <= '0;
      end
      ST_MWAIT: begin
        if (mul_done) torque_q <= torque_d;
      end
      ST_TANH: begin
        if (op_q == OP_SPRING_TANH) begin
          tv_q   <= tanh_val;
          band_q <= band_w;
        end else begin
          tr_q <= tanh_val;
        end
      end
      ST_DIFF: diff_q   <= diff_sat;
      ST_EXC:  excess_q <= excess_w;
      ST_EPR:  es_q     <= es_w;
      ST_EADD: torque_q <= torque_q - es_q;
      ST_FIN: begin
        if (out_free) begin
          out_q.torque    <= sat32(torque_q);
          out_q.saturated <= !fits32(torque_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MWAIT)
    else $error("multiplier finished outside the wait state");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("noise LFSR reached the all-zero lockup state");

  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.saturated) |-> (out_o.torque == S32_MAX || out_o.torque == S32_MIN))
    else $error("saturated flag set on an unclipped torque");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MSTART) |-> (op_q <= OP_NOISE_SCALE))
    else $error("product sequence ran past the last product");
`endif

endmodule

`default_nettype wire

[tb/sfft_torque_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfft_torque_checker: torque prediction and compare for the FFB block
// Watches the tick, result and register-write ports. Keeps its own copy of
// the registers, the drift angle and the rumble LFSR. For every accepted tick
// it computes the expected torque and clip flag and queues them. Every
// accepted result is checked against the oldest queued torque and clip flag.
// ----------------------------------------------------------------------------

module sfft_torque_checker import sfft_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam longint ONE30 = longint'(1) << 30;

  longint tanh_lut [0:TANH_DEPTH];

  longint angle_origin;
  longint spring_k;
  longint friction_k;
  longint damping_k;
  longint rumble_k;
  longint spring_speed_k;
  longint rumble_speed_k;
  longint end_stop;

  longint            drift;
  logic [DATA_W-1:0] rumble_lfsr;

  out_item_t torque_q [$];

  initial begin : build_lut
    longint              y;
    longint              term;
    longint              acc;
    longint unsigned     b;
    longint unsigned     p;
    longint unsigned     den;
    longint unsigned     num;
    y    = (longint'(8) << 30) / TANH_DEPTH;
    term = ONE30;
    acc  = ONE30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 30) / k;
      if (k % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    b = acc;
    p = ONE30;
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      den = ONE30 + p;
      num = (ONE30 - p) << FRAC_BITS;
      tanh_lut[i] = (num + den / 2) / den;
      p = (p * b + (ONE30 >> 1)) >> 30;
    end
  end

  function automatic longint clip32(longint v);
    if (v > longint'(S32_MAX)) return longint'(S32_MAX);
    if (v < longint'(S32_MIN)) return longint'(S32_MIN);
    return v;
  endfunction

  // sign-magnitude product, truncated toward zero, then clipped
  function automatic longint qmul(longint a, longint b);
    logic            neg;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    m   = (ma * mb) >> FRAC_BITS;
    if (m > (longint'(1) << 40)) m = longint'(1) << 40;
    return clip32(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint tanh_of(longint x);
    longint unsigned m;
    longint unsigned four;
    longint unsigned idx;
    four = 4 * ONE;
    m    = (x < 0) ? -x : x;
    if (m >= four) idx = TANH_DEPTH;
    else           idx = (m * TANH_DEPTH + four / 2) / four;
    if (idx > TANH_DEPTH) idx = TANH_DEPTH;
    return (x < 0) ? -tanh_lut[int'(idx)] : tanh_lut[int'(idx)];
  endfunction

  // advances drift and LFSR, so call once per accepted tick
  function automatic out_item_t calc_torque(in_item_t tick);
    longint    wa;
    longint    ws;
    longint    cs;
    longint    rough;
    longint    tv;
    longint    tr;
    longint    band;
    longint    angle;
    longint    diff;
    longint    noise;
    longint    acc;
    longint    clipped;
    logic      lsb;
    out_item_t res;
    wa    = longint'($signed(tick.wheel_angle));
    ws    = longint'($signed(tick.wheel_speed));
    cs    = longint'($signed(tick.car_speed));
    rough = longint'(tick.road_roughness);

    tv    = tanh_of(qmul(spring_speed_k, cs));
    tr    = tanh_of(qmul(rumble_speed_k, cs));
    band  = ONE - tv;
    angle = clip32(wa - angle_origin);

    acc = -qmul(qmul(angle, spring_k), tv);

    diff = drift - angle;
    if (diff > band)       drift = clip32(angle + band);
    else if (diff < -band) drift = clip32(angle - band);
    diff = clip32(drift - angle);
    acc  = acc + qmul(diff, friction_k);

    acc = acc - qmul(ws, damping_k);

    lsb         = rumble_lfsr[0];
    rumble_lfsr = rumble_lfsr >> 1;
    if (lsb) rumble_lfsr = rumble_lfsr ^ LFSR_TAPS;
    noise = longint'(rumble_lfsr[FRAC_BITS-1:0]) - ONE / 2;
    acc   = acc + qmul(qmul(qmul(noise, rough), rumble_k), tr);

    if (angle > end_stop)  acc = acc - (angle - end_stop) * END_STOP_GAIN;
    if (angle < -end_stop) acc = acc - (angle + end_stop) * END_STOP_GAIN;

    clipped       = clip32(acc);
    res.torque    = clipped[DATA_W-1:0];
    res.saturated = (clipped != acc);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors_o = errors_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      errors_o       = 0;
      angle_origin   = 0;
      spring_k       = 0;
      friction_k     = 0;
      damping_k      = 0;
      rumble_k       = 0;
      spring_speed_k = 0;
      rumble_speed_k = 0;
      end_stop       = longint'(END_STOP_RESET);
      drift          = 0;
      rumble_lfsr    = LFSR_SEED;
      torque_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ANGLE_ORIGIN:        angle_origin   = longint'($signed(cfg_data_i));
          REG_SPRING_GAIN:         spring_k       = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_FRICTION_GAIN:       friction_k     = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_DAMPING_GAIN:        damping_k      = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_RUMBLE_GAIN:         rumble_k       = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_SPEED_IMPACT:        spring_speed_k = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_RUMBLE_SPEED_IMPACT: rumble_speed_k = longint'(cfg_data_i[GAIN_W-1:0]);
          REG_END_STOP_ANGLE:      end_stop       = longint'(cfg_data_i[GAIN_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) torque_q.push_back(calc_torque(in_i));
      if (out_valid_i && !out_stall_i) begin
        if (torque_q.size() == 0) begin
          report_mismatch($sformatf("result with no tick pending, torque %0d",
                                    $signed(out_i.torque)));
        end else begin
          want = torque_q.pop_front();
          if (out_i.torque !== want.torque)
            report_mismatch($sformatf("torque %0d, expected %0d",
                                      $signed(out_i.torque), $signed(want.torque)));
          if (out_i.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b",
                                      out_i.saturated, want.saturated));
        end
      end
    end
    pending_o = torque_q.size();
  end

endmodule

[tb/tb_steering_force_feedback_torque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_steering_force_feedback_torque: testbench for the FFB torque block
// Drives ticks with random gaps and stalls the result side at random. A
// directed set covers field extremes, end stops, negative car speed and
// clipping; random phases follow under zero, maximum, random and realistic
// register settings. The checker predicts and compares each result.
// ----------------------------------------------------------------------------

module tb_steering_force_feedback_torque import sfft_pkg::*; ();

  localparam int     SETTLE_CYCLES   = 120;
  localparam int     PHASES          = 12;
  localparam int     TICKS_PER_PHASE = 125;
  localparam longint TIMEOUT_NS      = 64'd10_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  int                   errors;
  int                   pending;

  bit calm;         // no gaps and no stalls in this phase
  int walk;         // wheel angle relative to the origin for realistic ticks
  int origin_now;
  int stall_left;

  steering_force_feedback_torque u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  sfft_torque_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // result side: after each transaction hold stall for a drawn number of
  // cycles in which a result is offered
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_stall) begin
      if (out_valid) begin
        stall_left = stall_left - 1;
        if (stall_left <= 0) out_stall <= 1'b0;
      end
    end else if (out_valid) begin
      stall_left = draw_wait();
      if (stall_left > 0) out_stall <= 1'b1;
    end
  end

  task automatic send_tick(input logic [DATA_W-1:0] wa, ws, cs, rough);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{wa, ws, cs, rough[GAIN_W-1:0]};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_tick();
    if ($urandom_range(0, 4) == 0) begin
      send_tick($urandom, $urandom, $urandom, $urandom);
    end else begin
      if ($urandom_range(0, 15) == 0) walk = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
      else walk = walk + int'($urandom_range(0, ONE / 2)) - ONE / 4;
      if (walk > 4 * ONE)  walk = 4 * ONE;
      if (walk < -4 * ONE) walk = -4 * ONE;
      send_tick(origin_now + walk,
                int'($urandom_range(0, 8 * ONE)) - 4 * ONE,
                int'($urandom_range(0, 16 * ONE)) - 4 * ONE,
                $urandom_range(0, 2 * ONE));
    end
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] origin,
                               input logic [DATA_W-1:0] spring, friction, damping,
                               input logic [DATA_W-1:0] rumble, speed, rumble_speed,
                               input logic [DATA_W-1:0] stop_angle);
    origin_now = origin;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ANGLE_ORIGIN;
    cfg_data <= origin;
    @(posedge clk);
    cfg_idx  <= REG_SPRING_GAIN;
    cfg_data <= {1'b0, spring[GAIN_W-1:0]};
    @(posedge clk);
    cfg_idx  <= REG_FRICTION_GAIN;
    cfg_data <= {1'b0, friction[GAIN_W-1:0]};
    @(posedge clk);
    cfg_idx  <= REG_DAMPING_GAIN;
    cfg_data <= {1'b0, damping[GAIN_W-1:0]};
    @(posedge clk);
    cfg_idx  <= REG_RUMBLE_GAIN;
    cfg_data <= {1'b0, rumble[GAIN_W-1:0]};
    @(posedge clk);
    cfg_idx  <= REG_SPEED_IMPACT;
    cfg_data <= {1'b0, speed[GAIN_W-1:0]};
    @(posedge clk);
    cfg_idx  <= REG_RUMBLE_SPEED_IMPACT;
    cfg_data <= {1'b0, rumble_speed[GAIN_W-1:0]};
    @(posedge clk);
    cfg_idx  <= REG_END_STOP_ANGLE;
    cfg_data <= {1'b0, stop_angle[GAIN_W-1:0]};
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    in_valid   <= 1'b0;
    in_item    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= REG_ANGLE_ORIGIN;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    calm       = 1'b0;
    walk       = 0;
    origin_now = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: only the end stop at 1.5 rad acts
    send_tick(2 * ONE, 0, 0, 0);
    send_tick(-2 * ONE, 0, 0, 0);
    settle();

    load_settings(0, ONE, ONE, ONE, ONE, ONE, ONE, 3 * ONE / 2);
    send_tick(0, 0, 0, 0);
    send_tick(ONE / 2, 0, 2 * ONE, ONE);
    send_tick(-ONE / 2, 0, -2 * ONE, ONE);      // negative car speed, band above one
    send_tick(2 * ONE, 0, ONE, 0);
    send_tick(-2 * ONE, 0, ONE, 0);
    send_tick(0, 0, ONE, 0);                    // drift dragged back from the far end
    send_tick(ONE / 4, 0, 0, 0);
    send_tick(3 * ONE / 2, 0, ONE, 0);          // right at the end stop
    send_tick(3 * ONE / 2 + 1, 0, ONE, 0);
    send_tick(S32_MAX, 0, ONE, 0);              // torque clips
    send_tick(S32_MIN, 0, ONE, 0);
    send_tick(0, S32_MAX, 0, 0);
    send_tick(0, S32_MIN, 0, 0);
    send_tick(0, 0, S32_MAX, '1);
    send_tick(0, 0, S32_MIN, '1);
    send_tick(ONE, ONE, ONE, '1);
    settle();

    load_settings(S32_MIN, '1, '1, '1, '1, '1, '1, '0);
    send_tick(S32_MAX, S32_MAX, S32_MAX, '1);   // angle difference saturates
    send_tick(S32_MIN, S32_MIN, S32_MIN, '1);
    send_tick(0, 0, 0, '1);
    settle();

    load_settings(S32_MAX, '1, '1, '1, '1, '1, '1, '1);
    send_tick(S32_MIN, S32_MIN, S32_MAX, '1);
    send_tick(S32_MAX, 0, 0, 0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      walk = 0;
      case (ph)
        1: load_settings('0, '0, '0, '0, '0, '0, '0, '0);
        3: load_settings($urandom_range(0, 1) ? S32_MAX : S32_MIN,
                         '1, '1, '1, '1, '1, '1, '1);
        5, 9: load_settings($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
        default: load_settings(int'($urandom_range(0, 2 * ONE)) - ONE,
                               $urandom_range(0, 4 * ONE), $urandom_range(0, 4 * ONE),
                               $urandom_range(0, 4 * ONE), $urandom_range(0, 4 * ONE),
                               $urandom_range(0, ONE), $urandom_range(0, ONE),
                               $urandom_range(ONE / 2, 2 * ONE));
      endcase
      repeat (TICKS_PER_PHASE) send_random_tick();
      settle();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
